@@ sv/jtik_pkg.sv @@
`timescale 1ns / 1ps
// ============================================================================
// jtik_pkg
// Shared types and constants for the top-level id key detector: transaction
// payloads, the stack command bundle and the byte codes the scanner matches.
// ============================================================================
package jtik_pkg;

    // Built stack depth by default.
    localparam int DEFAULT_MAX_DEPTH = 64;

    // Byte codes.
    localparam logic [7:0] CH_I      = 8'h69;
    localparam logic [7:0] CH_D      = 8'h64;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_NUL    = 8'h00;

    // Key match progress codes.
    localparam logic [1:0] KEY_NONE  = 2'd0;
    localparam logic [1:0] KEY_I     = 2'd1;
    localparam logic [1:0] KEY_ID    = 2'd2;
    localparam logic [1:0] KEY_MISS  = 2'd3;

    // Input transaction payload.
    typedef struct packed {
        logic [7:0] text_byte;
        logic       last_byte;
    } t_in;

    // Output transaction payload.
    typedef struct packed {
        logic expects_response;
        logic depth_overflow;
    } t_out;

    // Command from the scanner to the container stack.
    typedef struct packed {
        logic clear;
        logic push;
        logic pop;
        logic is_obj;
    } t_stk_cmd;

endpackage

@@ sv/json_top_level_id_key_detector.sv @@
`timescale 1ns / 1ps
// The result of a line is registered, valid in the cycle after its last byte is taken.
// Throughput: one byte per cycle unless the output stalls; each byte's scan and its
// container stack update end in that cycle, the below-top entry prefetched from memory.
// Reset: synchronous, active low; clears the phase, the depth and the output valid.
// The stack memory needs no clearing, since every entry is written before its value is used.
// ============================================================================
// json_top_level_id_key_detector
// Decides per JSON text line whether it expects a reply: a top-level "id"
// key, a non-object line or malformed text gives true.
// ============================================================================
module json_top_level_id_key_detector import jtik_pkg::*; #(
    parameter int MAX_DEPTH = DEFAULT_MAX_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    localparam int DW = $clog2(MAX_DEPTH + 1);

    logic          take;
    t_stk_cmd      stk_cmd;
    logic [DW-1:0] depth;
    logic          top_obj;
    logic          res_valid;
    t_out          res;
    logic          r_out_valid;
    t_out          r_out_data;

    // A byte is taken unless a finished result is stalled in the output register.
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign take       = i_in_valid && o_in_ready;

    jtik_scan #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_data      (i_in_data),
        .i_depth     (depth),
        .i_top_obj   (top_obj),
        .o_cmd       (stk_cmd),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    jtik_stack #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_stack (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (stk_cmd),
        .o_depth   (depth),
        .o_top_obj (top_obj)
    );

    // Output register for the result transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_out_data <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

@@ sv/jtik_stack.sv @@
`timescale 1ns / 1ps
// ============================================================================
// jtik_stack
// Container stack: one bit per nesting level (1 = object, 0 = array) held in
// a synchronous memory. The top entry is mirrored in a register and the entry
// below it is prefetched every cycle, so a pop is ready in the next cycle.
// ============================================================================
module jtik_stack import jtik_pkg::*; #(
    parameter int MAX_DEPTH = DEFAULT_MAX_DEPTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  t_stk_cmd                       i_cmd,
    output logic [$clog2(MAX_DEPTH+1)-1:0] o_depth,
    output logic                           o_top_obj
);

    localparam int DW = $clog2(MAX_DEPTH + 1);
    localparam int AW = $clog2(MAX_DEPTH);

    logic          r_mem [MAX_DEPTH];
    logic [DW-1:0] r_depth;
    logic [DW-1:0] n_depth;
    logic [DW-1:0] rd_ptr;
    logic          r_top;
    logic          r_below;

    // Next depth; clearing wins over a push or pop in the same cycle.
    always_comb begin
        n_depth = r_depth;
        if (i_cmd.clear) begin
            n_depth = '0;
        end else if (i_cmd.push) begin
            n_depth = r_depth + DW'(1);
        end else if (i_cmd.pop && r_depth != '0) begin
            n_depth = r_depth - DW'(1);
        end
    end

    // Prefetch address: the entry just below the next top.
    assign rd_ptr = n_depth - DW'(2);

    // Depth counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth <= '0;
        end else begin
            r_depth <= n_depth;
        end
    end

    // Memory write on push and registered read of the entry below the top.
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_mem[r_depth[AW-1:0]] <= i_cmd.is_obj;
        end
        r_below <= r_mem[rd_ptr[AW-1:0]];
    end

    // Top-of-stack mirror.
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_top <= i_cmd.is_obj;
        end else if (i_cmd.pop) begin
            r_top <= r_below;
        end
    end

    assign o_depth   = r_depth;
    assign o_top_obj = (r_depth != '0) && r_top;

endmodule

@@ sv/jtik_scan.sv @@
`timescale 1ns / 1ps
// ============================================================================
// jtik_scan
// Byte scanner: tracks the parse phase, the key match and the line decision,
// and drives push and pop commands to the container stack.
// ============================================================================
module jtik_scan import jtik_pkg::*; #(
    parameter int MAX_DEPTH = DEFAULT_MAX_DEPTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_take,
    input  t_in                            i_data,
    input  logic [$clog2(MAX_DEPTH+1)-1:0] i_depth,
    input  logic                           i_top_obj,
    output t_stk_cmd                       o_cmd,
    output logic                           o_res_valid,
    output t_out                           o_res
);

    localparam int DW = $clog2(MAX_DEPTH + 1);

    typedef enum logic [3:0] {
        PH_LEAD, PH_OBJ_KEY, PH_KEY_STR, PH_KEY_ESC, PH_COLON, PH_VALUE,
        PH_ARR_ELEM, PH_VAL_STR, PH_VAL_ESC, PH_LIT, PH_AFTER
    } t_phase;

    t_phase     r_phase, n_phase;
    logic [1:0] r_key, n_key;
    logic       r_done, n_done;
    logic       r_val, n_val;
    logic       r_ovf, n_ovf;
    logic [7:0] b;
    logic       ws;
    logic       do_value, do_after, do_open, open_obj, do_close, do_key;

    assign b  = i_data.text_byte;
    assign ws = (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);

    // Next-state logic for one byte.
    always_comb begin
        n_phase   = r_phase;
        n_key     = r_key;
        n_done    = r_done;
        n_val     = r_val;
        n_ovf     = r_ovf;
        o_cmd     = '0;
        do_value  = 1'b0;
        do_after  = 1'b0;
        do_open   = 1'b0;
        open_obj  = 1'b0;
        do_close  = 1'b0;
        do_key    = 1'b0;

        if (i_take && !r_done) begin
            if (b == CH_NUL) begin
                n_done = 1'b1;
                n_val  = 1'b1;
            end else begin
                // Phase dispatch.
                unique case (r_phase)
                    PH_LEAD: begin
                        if (!ws) begin
                            if (b == CH_LBRACE) begin
                                do_open  = 1'b1;
                                open_obj = 1'b1;
                            end else begin
                                n_done = 1'b1;
                                n_val  = 1'b1;
                            end
                        end
                    end
                    PH_OBJ_KEY: begin
                        if (!ws) begin
                            if (b == CH_RBRACE) begin
                                do_close = 1'b1;
                            end else if (b == CH_QUOTE) begin
                                n_key   = KEY_NONE;
                                n_phase = PH_KEY_STR;
                            end else begin
                                n_done = 1'b1;
                                n_val  = 1'b1;
                            end
                        end
                    end
                    PH_KEY_STR: begin
                        if (b == CH_QUOTE) begin
                            n_phase = PH_COLON;
                        end else begin
                            do_key = 1'b1;
                            if (b == CH_BSLASH) begin
                                n_phase = PH_KEY_ESC;
                            end
                        end
                    end
                    PH_KEY_ESC: begin
                        do_key  = 1'b1;
                        n_phase = PH_KEY_STR;
                    end
                    PH_COLON: begin
                        if (!ws) begin
                            if (b != CH_COLON) begin
                                n_done = 1'b1;
                                n_val  = 1'b1;
                            end else if (i_depth == DW'(1) && r_key == KEY_ID) begin
                                n_done = 1'b1;
                                n_val  = 1'b1;
                            end else begin
                                n_phase = PH_VALUE;
                            end
                        end
                    end
                    PH_VALUE: begin
                        if (!ws) begin
                            do_value = 1'b1;
                        end
                    end
                    PH_ARR_ELEM: begin
                        if (!ws) begin
                            if (b == CH_RBRACK) begin
                                do_close = 1'b1;
                            end else begin
                                do_value = 1'b1;
                            end
                        end
                    end
                    PH_VAL_STR: begin
                        if (b == CH_BSLASH) begin
                            n_phase = PH_VAL_ESC;
                        end else if (b == CH_QUOTE) begin
                            n_phase = PH_AFTER;
                        end
                    end
                    PH_VAL_ESC: begin
                        n_phase = PH_VAL_STR;
                    end
                    PH_LIT: begin
                        if (ws || b == CH_COMMA || b == CH_RBRACE || b == CH_RBRACK) begin
                            n_phase  = PH_AFTER;
                            do_after = 1'b1;
                        end
                    end
                    PH_AFTER: begin
                        do_after = 1'b1;
                    end
                    default: begin
                        n_done = 1'b1;
                        n_val  = 1'b1;
                    end
                endcase

                // Key byte matching against the two raw bytes i,d.
                if (do_key) begin
                    unique case (r_key)
                        KEY_NONE: n_key = (b == CH_I) ? KEY_I : KEY_MISS;
                        KEY_I:    n_key = (b == CH_D) ? KEY_ID : KEY_MISS;
                        default:  n_key = KEY_MISS;
                    endcase
                end

                // Start of a value.
                if (do_value) begin
                    if (b == CH_LBRACE) begin
                        do_open  = 1'b1;
                        open_obj = 1'b1;
                    end else if (b == CH_LBRACK) begin
                        do_open = 1'b1;
                    end else if (b == CH_QUOTE) begin
                        n_phase = PH_VAL_STR;
                    end else if (b == CH_MINUS || (b >= CH_ZERO && b <= CH_NINE)
                                 || b == CH_T || b == CH_F || b == CH_N) begin
                        n_phase = PH_LIT;
                    end else begin
                        n_done = 1'b1;
                        n_val  = 1'b1;
                    end
                end

                // Separator or close after a complete value.
                if (do_after && !ws) begin
                    if (b == CH_COMMA) begin
                        n_phase = i_top_obj ? PH_OBJ_KEY : PH_ARR_ELEM;
                    end else if ((b == CH_RBRACE && i_top_obj)
                                 || (b == CH_RBRACK && !i_top_obj)) begin
                        do_close = 1'b1;
                    end else begin
                        n_done = 1'b1;
                        n_val  = 1'b1;
                    end
                end

                // Open a container, or flag overflow when the stack is full.
                if (do_open) begin
                    if (i_depth >= DW'(MAX_DEPTH)) begin
                        n_ovf  = 1'b1;
                        n_done = 1'b1;
                        n_val  = 1'b1;
                    end else begin
                        o_cmd.push   = 1'b1;
                        o_cmd.is_obj = open_obj;
                        n_phase      = open_obj ? PH_OBJ_KEY : PH_ARR_ELEM;
                    end
                end

                // Close a container; closing the outermost one decides the line.
                if (do_close) begin
                    o_cmd.pop = 1'b1;
                    if (i_depth <= DW'(1)) begin
                        n_done = 1'b1;
                        n_val  = 1'b0;
                    end else begin
                        n_phase = PH_AFTER;
                    end
                end
            end
        end

        // Result at the last byte, then line state returns to its start.
        o_res_valid            = i_take && i_data.last_byte;
        o_res.expects_response = n_done ? n_val : 1'b1;
        o_res.depth_overflow   = n_ovf;
        if (o_res_valid) begin
            o_cmd.clear = 1'b1;
            n_phase     = PH_LEAD;
            n_key       = KEY_NONE;
            n_done      = 1'b0;
            n_val       = 1'b0;
            n_ovf       = 1'b0;
        end
    end

    // Scanner state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_LEAD;
            r_key   <= KEY_NONE;
            r_done  <= 1'b0;
            r_val   <= 1'b0;
            r_ovf   <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_key   <= n_key;
            r_done  <= n_done;
            r_val   <= n_val;
            r_ovf   <= n_ovf;
        end
    end

endmodule
